// File: hdl/skvt_pkg.sv
// ----------------------------------------------------------------------------
// skvt_pkg: shared types and constants of the sorted key/value table
// Field widths, command and status codes, and the controller/datapath bundles.
// ----------------------------------------------------------------------------
package skvt_pkg;

  localparam int CAPACITY      = 16;
  localparam int CMD_W         = 3;
  localparam int KEY_W         = 32;
  localparam int VAL_W         = 32;
  localparam int STATUS_W      = 3;
  localparam int ENTRY_COUNT_W = 5;
  localparam int CNT_W         = $clog2(CAPACITY + 1);
  localparam int IDX_W         = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 3'd0,
    CMD_REMOVE = 3'd1,
    CMD_LOOKUP = 3'd2,
    CMD_CLEAR  = 3'd3,
    CMD_DUMP   = 3'd4
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 3'd0,
    ST_DUP      = 3'd1,
    ST_NOTFOUND = 3'd2,
    ST_FULL     = 3'd3,
    ST_EMPTY    = 3'd4
  } status_e;

  // controller -> datapath
  typedef struct packed {
    logic    load_req;
    logic    idx_clr;
    logic    idx_inc;
    logic    do_insert;
    logic    do_remove;
    logic    do_clear;
    logic    out_load;
    status_e out_status;
    logic    out_entry;
    logic    out_last;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [CMD_W-1:0] command;
    logic             scan_more;
    logic             hit;
    logic             full;
    logic             empty;
    logic             dump_last;
    logic             out_free;
  } dp_sts_t;

endpackage

// File: hdl/skvt_if.sv
// ----------------------------------------------------------------------------
// skvt_if: request and response channels of the sorted key/value table
// Valid/ready channels; a beat moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface skvt_req_if;
  logic                                valid;
  logic                                ready;
  logic        [skvt_pkg::CMD_W-1:0]   command;
  logic signed [skvt_pkg::KEY_W-1:0]   key;
  logic signed [skvt_pkg::VAL_W-1:0]   value;

  modport source (output valid, command, key, value, input ready);
  modport sink   (input valid, command, key, value, output ready);
endinterface

interface skvt_rsp_if;
  logic                                     valid;
  logic                                     ready;
  logic        [skvt_pkg::STATUS_W-1:0]     status;
  logic signed [skvt_pkg::KEY_W-1:0]        out_key;
  logic signed [skvt_pkg::VAL_W-1:0]        out_value;
  logic        [skvt_pkg::ENTRY_COUNT_W-1:0] entry_count;
  logic                                     last;

  modport source (output valid, status, out_key, out_value, entry_count, last, input ready);
  modport sink   (input valid, status, out_key, out_value, entry_count, last, output ready);
endinterface

// File: hdl/skvt_dp.sv
// ----------------------------------------------------------------------------
// skvt_dp: datapath of the sorted key/value table
// Entry row with neighbor shifting, scan index, fill count and output register.
// ----------------------------------------------------------------------------
module skvt_dp (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  skvt_pkg::dp_cmd_t                         cmd_i,
  output skvt_pkg::dp_sts_t                         sts_o,
  input  logic        [skvt_pkg::CMD_W-1:0]         req_command_i,
  input  logic signed [skvt_pkg::KEY_W-1:0]         req_key_i,
  input  logic signed [skvt_pkg::VAL_W-1:0]         req_value_i,
  output logic                                      rsp_valid_o,
  input  logic                                      rsp_ready_i,
  output logic        [skvt_pkg::STATUS_W-1:0]      rsp_status_o,
  output logic signed [skvt_pkg::KEY_W-1:0]         rsp_key_o,
  output logic signed [skvt_pkg::VAL_W-1:0]         rsp_value_o,
  output logic        [skvt_pkg::ENTRY_COUNT_W-1:0] rsp_count_o,
  output logic                                      rsp_last_o
);

  localparam int CNT_W = skvt_pkg::CNT_W;
  localparam int IDX_W = skvt_pkg::IDX_W;

  logic signed [skvt_pkg::KEY_W-1:0] key_q [skvt_pkg::CAPACITY];
  logic signed [skvt_pkg::VAL_W-1:0] val_q [skvt_pkg::CAPACITY];

  logic        [skvt_pkg::CMD_W-1:0] cmd_q;
  logic signed [skvt_pkg::KEY_W-1:0] in_key_q;
  logic signed [skvt_pkg::VAL_W-1:0] in_val_q;

  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] idx_q, idx_d;

  logic signed [skvt_pkg::KEY_W-1:0] rd_key;
  logic signed [skvt_pkg::VAL_W-1:0] rd_val;
  logic                              in_range;

  logic                                      out_valid_q, out_valid_d;
  logic        [skvt_pkg::STATUS_W-1:0]      out_status_q;
  logic signed [skvt_pkg::KEY_W-1:0]         out_key_q;
  logic signed [skvt_pkg::VAL_W-1:0]         out_val_q;
  logic        [skvt_pkg::ENTRY_COUNT_W-1:0] out_count_q;
  logic                                      out_last_q;

  assign rd_key   = key_q[idx_q[IDX_W-1:0]];
  assign rd_val   = val_q[idx_q[IDX_W-1:0]];
  assign in_range = idx_q < count_q;

  always_comb begin
    sts_o.command   = cmd_q;
    sts_o.scan_more = in_range && (rd_key < in_key_q);
    sts_o.hit       = in_range && (rd_key == in_key_q);
    sts_o.full      = count_q == CNT_W'(skvt_pkg::CAPACITY);
    sts_o.empty     = count_q == '0;
    sts_o.dump_last = (idx_q + CNT_W'(1)) == count_q;
    sts_o.out_free  = !out_valid_q || rsp_ready_i;
  end

  always_comb begin
    count_d = count_q;
    if (cmd_i.do_clear) begin
      count_d = '0;
    end else if (cmd_i.do_insert) begin
      count_d = count_q + CNT_W'(1);
    end else if (cmd_i.do_remove) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_comb begin
    idx_d = idx_q;
    if (cmd_i.idx_clr) begin
      idx_d = '0;
    end else if (cmd_i.idx_inc) begin
      idx_d = idx_q + CNT_W'(1);
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.out_load) begin
      out_valid_d = 1'b1;
    end else if (rsp_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) begin
      cmd_q    <= req_command_i;
      in_key_q <= req_key_i;
      in_val_q <= req_value_i;
    end
    if (cmd_i.out_load) begin
      out_status_q <= cmd_i.out_status;
      out_key_q    <= cmd_i.out_entry ? rd_key : '0;
      out_val_q    <= cmd_i.out_entry ? rd_val : '0;
      out_count_q  <= skvt_pkg::ENTRY_COUNT_W'(count_d);
      out_last_q   <= cmd_i.out_last;
    end
  end

  // Each entry takes its new pair, its lower neighbor (insert) or its upper
  // neighbor (remove), relative to the scan index.
  for (genvar i = 0; i < skvt_pkg::CAPACITY; i++) begin : g_entry
    logic signed [skvt_pkg::KEY_W-1:0] up_key, dn_key;
    logic signed [skvt_pkg::VAL_W-1:0] up_val, dn_val;

    if (i > 0) begin : g_up
      assign up_key = key_q[i-1];
      assign up_val = val_q[i-1];
    end else begin : g_up_none
      assign up_key = '0;
      assign up_val = '0;
    end

    if (i < skvt_pkg::CAPACITY - 1) begin : g_dn
      assign dn_key = key_q[i+1];
      assign dn_val = val_q[i+1];
    end else begin : g_dn_none
      assign dn_key = '0;
      assign dn_val = '0;
    end

    always_ff @(posedge clk_i) begin
      if (cmd_i.do_insert && (CNT_W'(i) == idx_q)) begin
        key_q[i] <= in_key_q;
        val_q[i] <= in_val_q;
      end else if (cmd_i.do_insert && (CNT_W'(i) > idx_q)) begin
        key_q[i] <= up_key;
        val_q[i] <= up_val;
      end else if (cmd_i.do_remove && (CNT_W'(i) >= idx_q)) begin
        key_q[i] <= dn_key;
        val_q[i] <= dn_val;
      end
    end
  end

  assign rsp_valid_o  = out_valid_q;
  assign rsp_status_o = out_status_q;
  assign rsp_key_o    = out_key_q;
  assign rsp_value_o  = out_val_q;
  assign rsp_count_o  = out_count_q;
  assign rsp_last_o   = out_last_q;

endmodule

// File: hdl/skvt_ctrl.sv
// ----------------------------------------------------------------------------
// skvt_ctrl: controller of the sorted key/value table
// Accepts a command, steps the key scan, then issues the update and results.
// ----------------------------------------------------------------------------
module skvt_ctrl (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         req_valid_i,
  input  logic [skvt_pkg::CMD_W-1:0]   req_command_i,
  output logic                         req_ready_o,
  input  skvt_pkg::dp_sts_t            sts_i,
  output skvt_pkg::dp_cmd_t            cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SCAN = 4'b0010,
    S_RESP = 4'b0100,
    S_DUMP = 4'b1000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d     = state_q;
    req_ready_o = 1'b0;
    cmd_o       = '0;
    unique case (state_q)
      S_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          cmd_o.load_req = 1'b1;
          cmd_o.idx_clr  = 1'b1;
          case (req_command_i) inside
            skvt_pkg::CMD_INSERT, skvt_pkg::CMD_REMOVE, skvt_pkg::CMD_LOOKUP: begin
              state_d = S_SCAN;
            end
            skvt_pkg::CMD_DUMP: state_d = S_DUMP;
            default:            state_d = S_RESP;
          endcase
        end
      end
      S_SCAN: begin
        // advance past smaller keys; stop at the lower bound
        if (sts_i.scan_more) begin
          cmd_o.idx_inc = 1'b1;
        end else begin
          state_d = S_RESP;
        end
      end
      S_RESP: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_last = 1'b1;
          state_d        = S_IDLE;
          case (sts_i.command)
            skvt_pkg::CMD_INSERT: begin
              if (sts_i.hit) begin
                cmd_o.out_status = skvt_pkg::ST_DUP;
              end else if (sts_i.full) begin
                cmd_o.out_status = skvt_pkg::ST_FULL;
              end else begin
                cmd_o.do_insert = 1'b1;
              end
            end
            skvt_pkg::CMD_REMOVE: begin
              if (sts_i.hit) begin
                cmd_o.do_remove = 1'b1;
              end else begin
                cmd_o.out_status = skvt_pkg::ST_NOTFOUND;
              end
            end
            skvt_pkg::CMD_LOOKUP: begin
              if (sts_i.hit) begin
                cmd_o.out_entry = 1'b1;
              end else begin
                cmd_o.out_status = skvt_pkg::ST_NOTFOUND;
              end
            end
            skvt_pkg::CMD_CLEAR: cmd_o.do_clear = 1'b1;
            default: ;
          endcase
        end
      end
      S_DUMP: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          if (sts_i.empty) begin
            cmd_o.out_status = skvt_pkg::ST_EMPTY;
            cmd_o.out_last   = 1'b1;
            state_d          = S_IDLE;
          end else begin
            cmd_o.out_entry = 1'b1;
            cmd_o.out_last  = sts_i.dump_last;
            cmd_o.idx_inc   = 1'b1;
            if (sts_i.dump_last) begin
              state_d = S_IDLE;
            end
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// File: hdl/sorted_key_value_table.sv
// ----------------------------------------------------------------------------
// sorted_key_value_table: sorted table of unique signed keys with data
// Insert, remove, lookup, clear and in-order dump over up to CAPACITY pairs.
// ----------------------------------------------------------------------------
// Each request beat is taken when the block is idle and answered on the
// response channel; a finished response waits in an output register, so the
// next request is taken while it is still pending. Insert, remove and lookup
// scan the stored keys one entry per cycle from the lowest, stopping at the
// first key not below the request key or at the end of the stored entries;
// the shift of the entry row on insert or remove is done in the same cycle
// as the response. Dump emits one beat per cycle while the sink is ready,
// one for each stored entry in ascending key order, or a single empty-table
// beat. There is no clearing pass after reset: the fill count alone marks
// which entries hold data.
module sorted_key_value_table (
  input  logic       clk_i,
  input  logic       rst_ni,
  skvt_req_if.sink   req_i,
  skvt_rsp_if.source rsp_o
);

  skvt_pkg::dp_cmd_t dp_cmd;
  skvt_pkg::dp_sts_t dp_sts;

  skvt_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_valid_i   (req_i.valid),
    .req_command_i (req_i.command),
    .req_ready_o   (req_i.ready),
    .sts_i         (dp_sts),
    .cmd_o         (dp_cmd)
  );

  skvt_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (dp_cmd),
    .sts_o         (dp_sts),
    .req_command_i (req_i.command),
    .req_key_i     (req_i.key),
    .req_value_i   (req_i.value),
    .rsp_valid_o   (rsp_o.valid),
    .rsp_ready_i   (rsp_o.ready),
    .rsp_status_o  (rsp_o.status),
    .rsp_key_o     (rsp_o.out_key),
    .rsp_value_o   (rsp_o.out_value),
    .rsp_count_o   (rsp_o.entry_count),
    .rsp_last_o    (rsp_o.last)
  );

  // a new response never overwrites one the sink has not taken
  a_out_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dp_cmd.out_load |-> dp_sts.out_free)
    else $error("response loaded over a pending beat");

  // insert only into a table with room and without the key
  a_insert_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dp_cmd.do_insert |-> (!dp_sts.full && !dp_sts.hit))
    else $error("insert into full table or over a present key");

  // remove only a key that the scan found
  a_remove_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dp_cmd.do_remove |-> dp_sts.hit)
    else $error("remove of a missing key");

  // no request is taken while the table is being updated
  a_accept_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready) |-> !(dp_cmd.do_insert || dp_cmd.do_remove ||
                                       dp_cmd.out_load))
    else $error("request taken during an update");

endmodule
